### src/edenc_pkg.sv
// Shared constants and helpers for the Elias delta encoder.
// Depends on nothing; every other file of the block refers to it by scoped names.
package edenc_pkg;

	localparam int VALUE_IN_W        = 32;
	localparam int DEF_VALUE_WIDTH   = 32;
	localparam int CODE_W            = 48;
	localparam int BITS_W            = 6;
	localparam int BYTES_W           = 3;
	localparam int SHIFT_W           = 7;

	// Mask of the k low bits of a code word; k of CODE_W or more gives all ones.
	function automatic logic [CODE_W-1:0] low_mask(input logic [SHIFT_W-1:0] k);
		logic [CODE_W:0] one_hot;
		one_hot = (CODE_W+1)'(1) << k;
		return one_hot[CODE_W-1:0] - CODE_W'(1);
	endfunction

endpackage

### src/edenc_if.sv
// Handshake channels of the Elias delta encoder: input value beats and code beats.
// Depends on edenc_pkg for the field widths.
interface edenc_value_if;
	logic                              valid;
	logic                              ready;
	logic [edenc_pkg::VALUE_IN_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface edenc_code_if;
	logic                            valid;
	logic                            ready;
	logic [edenc_pkg::CODE_W-1:0]    packed_code;
	logic [edenc_pkg::BITS_W-1:0]    code_bits;
	logic [edenc_pkg::BYTES_W-1:0]   code_bytes;
	logic                            zero_error;

	modport source (output valid, output packed_code, output code_bits, output code_bytes,
		output zero_error, input ready);
	modport sink (input valid, input packed_code, input code_bits, input code_bytes,
		input zero_error, output ready);
endinterface

### src/elias_delta_encoder_unit.sv
// Elias delta encoder: one value beat in, one packed code beat out.
// An accepted value beat is registered by the log, field and pack stages in turn.
// Throughput is one beat per cycle; each of the three register stages stalls on its own
// only when it holds a beat that the next stage cannot take.
// Reset clears the valid bits of all stages; payload registers are not reset.
// Depends on edenc_pkg, edenc_if and the three stage modules.
module elias_delta_encoder_unit #(
	parameter int VALUE_WIDTH = edenc_pkg::DEF_VALUE_WIDTH,
	localparam int NW = $clog2(VALUE_WIDTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	edenc_value_if.sink   value_ch,
	edenc_code_if.source  code_ch
);

	logic                          valid_s1;
	logic [VALUE_WIDTH-1:0]        val_s1;
	logic [NW-1:0]                 top_s1;
	logic                          zero_s1;
	logic                          ready_s1;
	logic                          valid_s2;
	logic [edenc_pkg::CODE_W-1:0]  head_s2;
	logic [edenc_pkg::SHIFT_W-1:0] hbits_s2;
	logic [VALUE_WIDTH-1:0]        tail_s2;
	logic [edenc_pkg::BITS_W-1:0]  bits_s2;
	logic                          zero_s2;
	logic                          ready_s2;

	edenc_log_stage #(.VALUE_WIDTH(VALUE_WIDTH)) u_log (
		.clk        (clk),
		.arst_n     (arst_n),
		.value_ch   (value_ch),
		.next_ready (ready_s1),
		.valid_s1   (valid_s1),
		.val_s1     (val_s1),
		.top_s1     (top_s1),
		.zero_s1    (zero_s1)
	);

	edenc_field_stage #(.VALUE_WIDTH(VALUE_WIDTH)) u_field (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.val_s1     (val_s1),
		.top_s1     (top_s1),
		.zero_s1    (zero_s1),
		.ready_s1   (ready_s1),
		.next_ready (ready_s2),
		.valid_s2   (valid_s2),
		.head_s2    (head_s2),
		.hbits_s2   (hbits_s2),
		.tail_s2    (tail_s2),
		.bits_s2    (bits_s2),
		.zero_s2    (zero_s2)
	);

	edenc_pack_stage #(.VALUE_WIDTH(VALUE_WIDTH)) u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.head_s2  (head_s2),
		.hbits_s2 (hbits_s2),
		.tail_s2  (tail_s2),
		.bits_s2  (bits_s2),
		.zero_s2  (zero_s2),
		.ready_s2 (ready_s2),
		.code_ch  (code_ch)
	);

endmodule

### src/edenc_log_stage.sv
// First pipeline stage: trims the value and finds its leading one (N) and the zero case.
// Depends on edenc_pkg and edenc_value_if.
module edenc_log_stage #(
	parameter int VALUE_WIDTH = edenc_pkg::DEF_VALUE_WIDTH,
	localparam int NW = $clog2(VALUE_WIDTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	edenc_value_if.sink            value_ch,
	input  logic                   next_ready,
	output logic                   valid_s1,
	output logic [VALUE_WIDTH-1:0] val_s1,
	output logic [NW-1:0]          top_s1,
	output logic                   zero_s1
);

	logic [VALUE_WIDTH-1:0] n;
	logic [NW-1:0]          top;
	logic                   en;

	assign n  = value_ch.value[VALUE_WIDTH-1:0];
	assign en = !valid_s1 || next_ready;
	assign value_ch.ready = en;

	always_comb begin
		top = '0;
		for (int i = 0; i < VALUE_WIDTH; i++) begin
			if (n[i]) begin
				top = NW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= value_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && value_ch.valid) begin
			val_s1  <= n;
			top_s1  <= top;
			zero_s1 <= ~|n;
		end
	end

endmodule

### src/edenc_field_stage.sv
// Second pipeline stage: builds the unary prefix with the length field of N+1,
// strips the leading one of the value and sums the code length.
// Depends on edenc_pkg.
module edenc_field_stage #(
	parameter int VALUE_WIDTH = edenc_pkg::DEF_VALUE_WIDTH,
	localparam int NW = $clog2(VALUE_WIDTH),
	localparam int LW = $clog2(NW + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  logic [VALUE_WIDTH-1:0]        val_s1,
	input  logic [NW-1:0]                 top_s1,
	input  logic                          zero_s1,
	output logic                          ready_s1,
	input  logic                          next_ready,
	output logic                          valid_s2,
	output logic [edenc_pkg::CODE_W-1:0]  head_s2,
	output logic [edenc_pkg::SHIFT_W-1:0] hbits_s2,
	output logic [VALUE_WIDTH-1:0]        tail_s2,
	output logic [edenc_pkg::BITS_W-1:0]  bits_s2,
	output logic                          zero_s2
);

	logic [NW:0]                    np1;
	logic [LW-1:0]                  len;
	logic [edenc_pkg::SHIFT_W-1:0]  len_w;
	logic [edenc_pkg::CODE_W-1:0]   len_mask;
	logic [edenc_pkg::CODE_W-1:0]   head;
	logic [edenc_pkg::SHIFT_W-1:0]  hbits;
	logic [edenc_pkg::CODE_W-1:0]   tail_full;
	logic                           en;

	assign en       = !valid_s2 || next_ready;
	assign ready_s1 = en;
	assign np1      = {1'b0, top_s1} + (NW+1)'(1);

	always_comb begin
		len = '0;
		for (int i = 0; i <= NW; i++) begin
			if (np1[i]) begin
				len = LW'(i);
			end
		end
	end

	// Prefix: len ones, a zero, then the len low bits of N+1 starting at bit len+1.
	assign len_w    = edenc_pkg::SHIFT_W'(len);
	assign len_mask = edenc_pkg::low_mask(len_w);
	assign head     = len_mask
		| ((edenc_pkg::CODE_W'(np1) & len_mask) << (len_w + edenc_pkg::SHIFT_W'(1)));
	assign hbits    = (len_w << 1) + edenc_pkg::SHIFT_W'(1);
	assign tail_full = edenc_pkg::CODE_W'(val_s1)
		& edenc_pkg::low_mask(edenc_pkg::SHIFT_W'(top_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			head_s2  <= head;
			hbits_s2 <= hbits;
			tail_s2  <= tail_full[VALUE_WIDTH-1:0];
			bits_s2  <= edenc_pkg::BITS_W'(hbits) + edenc_pkg::BITS_W'(top_s1);
			zero_s2  <= zero_s1;
		end
	end

endmodule

### src/edenc_pack_stage.sv
// Third pipeline stage: places the value bits above the prefix, pads the last byte
// with ones and drives the registered code beat; a zero value sets zero_error.
// Depends on edenc_pkg and edenc_code_if.
module edenc_pack_stage #(
	parameter int VALUE_WIDTH = edenc_pkg::DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s2,
	input  logic [edenc_pkg::CODE_W-1:0]  head_s2,
	input  logic [edenc_pkg::SHIFT_W-1:0] hbits_s2,
	input  logic [VALUE_WIDTH-1:0]        tail_s2,
	input  logic [edenc_pkg::BITS_W-1:0]  bits_s2,
	input  logic                          zero_s2,
	output logic                          ready_s2,
	edenc_code_if.source                  code_ch
);

	logic [edenc_pkg::SHIFT_W-1:0] bits_round;
	logic [edenc_pkg::BYTES_W-1:0] nbytes;
	logic [edenc_pkg::SHIFT_W-1:0] total;
	logic [edenc_pkg::CODE_W-1:0]  code;
	logic                          en;

	assign en       = !code_ch.valid || code_ch.ready;
	assign ready_s2 = en;

	assign bits_round = edenc_pkg::SHIFT_W'(bits_s2) + edenc_pkg::SHIFT_W'(7);
	assign nbytes     = bits_round[edenc_pkg::BYTES_W+2:3];
	assign total      = edenc_pkg::SHIFT_W'({nbytes, 3'b000});
	assign code       = head_s2
		| (edenc_pkg::CODE_W'(tail_s2) << hbits_s2)
		| (edenc_pkg::low_mask(total) & ~edenc_pkg::low_mask(edenc_pkg::SHIFT_W'(bits_s2)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_ch.valid <= 1'b0;
		end else if (en) begin
			code_ch.valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			if (zero_s2) begin
				code_ch.packed_code <= '0;
				code_ch.code_bits   <= '0;
				code_ch.code_bytes  <= '0;
				code_ch.zero_error  <= 1'b1;
			end else begin
				code_ch.packed_code <= code;
				code_ch.code_bits   <= bits_s2;
				code_ch.code_bytes  <= nbytes;
				code_ch.zero_error  <= 1'b0;
			end
		end
	end

endmodule
